@@ hdl/ctp_pkg.sv @@
// package for the countdown timer pool: request and response types, command codes
`timescale 1ns / 1ps
`default_nettype none

package ctp_pkg;

   localparam int NUM_TIMERS_DEFAULT = 8;
   localparam int COUNT_W = 32;

   localparam logic [2:0] CMD_ALLOCATE = 3'd0;
   localparam logic [2:0] CMD_RELEASE  = 3'd1;
   localparam logic [2:0] CMD_LOAD     = 3'd2;
   localparam logic [2:0] CMD_READ     = 3'd3;
   localparam logic [2:0] CMD_TICK     = 3'd4;

   typedef struct packed {
      logic [2:0]         command;
      logic [7:0]         timer_index;
      logic [COUNT_W-1:0] load_value;
   } req_type;

   typedef struct packed {
      logic [2:0]         handle;
      logic [COUNT_W-1:0] count_value;
      logic               none_free;
      logic               rejected;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/ctp_count_ram.sv @@
// count memory: one write port, one registered read port, per-entry written bits
`timescale 1ns / 1ps
`default_nettype none

module ctp_count_ram
   import ctp_pkg::*;
#(
   parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT,
   parameter int IDX_W = 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire logic [IDX_W-1:0]   wr_addr,
   input  wire logic [COUNT_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [IDX_W-1:0]   rd_addr,
   output logic      [COUNT_W-1:0] rd_data
);

   logic [COUNT_W-1:0] mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] written_ff;
   logic [COUNT_W-1:0] rd_q_ff;
   logic rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   // entries never written read as zero, matching the reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_written_ff ? rd_q_ff : '0;

endmodule

`default_nettype wire

@@ hdl/ctp_free_bank.sv @@
// free marks of all timers with lowest-free search for allocate
`timescale 1ns / 1ps
`default_nettype none

module ctp_free_bank
   import ctp_pkg::*;
#(
   parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT,
   parameter int IDX_W = 3
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  claim,
   input  wire logic                  release_en,
   input  wire logic [IDX_W-1:0]      release_addr,
   output logic                       any_free,
   output logic      [IDX_W-1:0]      claim_idx,
   output logic      [NUM_TIMERS-1:0] free_vec
);

   logic [NUM_TIMERS-1:0] free_ff;

   // priority encoder, lowest index wins
   always_comb begin
      claim_idx = '0;
      for (int k = NUM_TIMERS - 1; k >= 0; k--) begin
         if (free_ff[k]) begin
            claim_idx = IDX_W'(k);
         end
      end
   end

   assign any_free = |free_ff;
   assign free_vec = free_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '1;
      end else if (claim && any_free) begin
         free_ff[claim_idx] <= 1'b0;
      end else if (release_en) begin
         free_ff[release_addr] <= 1'b1;
      end
   end

endmodule

`default_nettype wire

@@ hdl/countdown_timer_pool_unit.sv @@
// countdown timer pool top level: command sequencer, tick sweep and response register
`timescale 1ns / 1ps
`default_nettype none

// usage
//   req channel carries one command (allocate, release, load, read, tick) per request;
//   rsp channel returns exactly one response per request, in request order
//   counts live in a one-port-read, one-port-write memory with a registered read port;
//   free marks live in flip-flops with a lowest-free priority encoder
//   allocate, release, load and unused codes: response in the cycle after acceptance,
//   next request may be taken the following cycle
//   read: the count goes into the memory read register, then from ST_READ into the response register
//   tick: response registered at once, then the block sweeps the count memory one
//   entry per cycle (read, then decrement and write back allocated, nonzero entries),
//   busy through ST_TICK and ST_DRAIN; the count memory port sets this pace
//   reset: all timers free, all counts zero; per-entry written bits make unwritten
//   entries read as zero, so no clearing pass is needed
//   rsp_stall holds the response register; a new request is taken only when the
//   register is empty or being taken in the same cycle

module countdown_timer_pool_unit
   import ctp_pkg::*;
#(
   parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_TICK  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic wb_valid_ff;
   logic [IDX_W-1:0] wb_addr_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // memory and free bank controls
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [COUNT_W-1:0] wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [COUNT_W-1:0] rd_data;
   logic               claim;
   logic               release_en;
   logic               any_free;
   logic [IDX_W-1:0]   claim_idx;
   logic [NUM_TIMERS-1:0] free_vec;

   logic accept;
   logic in_range;
   logic [IDX_W-1:0] req_addr;
   logic push;
   rsp_type push_data;

   ctp_count_ram #(
      .NUM_TIMERS (NUM_TIMERS),
      .IDX_W      (IDX_W)
   ) u_count_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ctp_free_bank #(
      .NUM_TIMERS (NUM_TIMERS),
      .IDX_W      (IDX_W)
   ) u_free_bank (
      .clock        (clock),
      .reset        (reset),
      .claim        (claim),
      .release_en   (release_en),
      .release_addr (req_addr),
      .any_free     (any_free),
      .claim_idx    (claim_idx),
      .free_vec     (free_vec)
   );

   // take a request only when idle and the response slot frees up
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign in_range  = {1'b0, req_data.timer_index} < 9'(NUM_TIMERS);
   assign req_addr  = req_data.timer_index[IDX_W-1:0];

   assign claim      = accept && (req_data.command == CMD_ALLOCATE);
   assign release_en = accept && (req_data.command == CMD_RELEASE) && in_range;

   always_comb begin
      state_in  = state_ff;
      sweep_in  = sweep_ff;
      wr_en     = 1'b0;
      wr_addr   = req_addr;
      wr_data   = req_data.load_value;
      rd_en     = 1'b0;
      rd_addr   = req_addr;
      push      = 1'b0;
      push_data = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               push = 1'b1;
               case (req_data.command)
                  CMD_ALLOCATE: begin
                     push_data.none_free = !any_free;
                     push_data.handle    = any_free ? 3'(claim_idx) : 3'd0;
                  end
                  CMD_RELEASE: begin
                     push_data.rejected = !in_range;
                  end
                  CMD_LOAD: begin
                     // load of a free timer is refused
                     if (in_range && !free_vec[req_addr]) begin
                        wr_en = 1'b1;
                     end else begin
                        push_data.rejected = 1'b1;
                     end
                  end
                  CMD_READ: begin
                     if (in_range) begin
                        // response waits for the memory read
                        push     = 1'b0;
                        rd_en    = 1'b1;
                        state_in = ST_READ;
                     end else begin
                        push_data.rejected = 1'b1;
                     end
                  end
                  CMD_TICK: begin
                     sweep_in = '0;
                     state_in = ST_TICK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            push                  = 1'b1;
            push_data.count_value = rd_data;
            state_in              = ST_IDLE;
         end
         ST_TICK: begin
            rd_en   = 1'b1;
            rd_addr = sweep_ff;
            if (sweep_ff == IDX_W'(NUM_TIMERS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // tick write-back, one entry behind the read; addresses never collide
      if (wb_valid_ff) begin
         wr_addr = wb_addr_ff;
         wr_data = rd_data - 1'b1;
         wr_en   = !free_vec[wb_addr_ff] && (rd_data != '0);
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push_data;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sweep_ff     <= '0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         wb_valid_ff  <= (state_ff == ST_TICK);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff  <= sweep_ff;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
